// ===== src/upti_pkg.sv =====
// Shared types and constants for the partitioned table insert unit.
// No dependencies; every other file in src uses this package by scoped names.
package upti_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;

    localparam int SITE_W   = 20;
    localparam int KIND_W   = 16;
    localparam int CFG_W    = 21;
    localparam int SLOT_W   = 8;

    localparam logic [CFG_W-1:0] SITE_COUNT_RST = 21'h100000;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_DUP     = 2'd3
    } t_status;

    typedef struct packed {
        logic [SITE_W-1:0] site;
        logic [KIND_W-1:0] kind;
        logic              mobile;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    search_step;
        logic    shift_init;
        logic    shift_step;
        logic    place;
        logic    reject;
        t_status reject_code;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic invalid;
        logic full;
        logic dup_hit;
        logic search_done;
        logic shift_done;
    } t_dp_stat;

endpackage

// ===== src/upti_if.sv =====
// Valid/ready channel interfaces for insert requests and their results.
// Depends on upti_pkg for field widths.
interface upti_in_if;
    logic                               valid;
    logic                               ready;
    logic        [upti_pkg::SITE_W-1:0] site_index;
    logic signed [upti_pkg::KIND_W-1:0] site_type;
    logic                               mobile;

    modport source (output valid, site_index, site_type, mobile, input ready);
    modport sink   (input valid, site_index, site_type, mobile, output ready);
endinterface

interface upti_out_if;
    logic                               valid;
    logic                               ready;
    logic        [1:0]                  status;
    logic        [upti_pkg::SLOT_W-1:0] slot;
    logic        [upti_pkg::SITE_W-1:0] grid_write_index;
    logic signed [upti_pkg::KIND_W-1:0] grid_write_type;

    modport source (output valid, status, slot, grid_write_index, grid_write_type,
                    input ready);
    modport sink   (input valid, status, slot, grid_write_index, grid_write_type,
                    output ready);
endinterface

// ===== src/upti_ctrl.sv =====
// Sequencing state machine for the insert unit: check, search, shift, place.
// Depends on upti_pkg; drives commands into upti_dp and reads its status.
module upti_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    input  upti_pkg::t_dp_stat i_stat,
    output upti_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_SEARCH = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_PLACE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.invalid || i_stat.full) begin
                    if (out_free) begin
                        o_cmd.reject = 1'b1;
                        if (i_stat.invalid) begin
                            o_cmd.reject_code = upti_pkg::ST_INVALID;
                        end else begin
                            o_cmd.reject_code = upti_pkg::ST_FULL;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_stat.dup_hit) begin
                    if (out_free) begin
                        o_cmd.reject      = 1'b1;
                        o_cmd.reject_code = upti_pkg::ST_DUP;
                        n_state           = S_IDLE;
                    end
                end else if (i_stat.search_done) begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHIFT;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_PLACE: begin
                if (out_free) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.place || o_cmd.reject) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/upti_dp.sv =====
// Datapath of the insert unit: entry memory, counters, walk pointer, result regs.
// Depends on upti_pkg; commanded by upti_ctrl.
module upti_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic        [upti_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic        [upti_pkg::SITE_W-1:0] i_site_index,
    input  logic signed [upti_pkg::KIND_W-1:0] i_site_type,
    input  logic                               i_mobile,
    input  upti_pkg::t_dp_cmd                  i_cmd,
    output upti_pkg::t_dp_stat                 o_stat,
    output logic        [1:0]                  o_status,
    output logic        [upti_pkg::SLOT_W-1:0] o_slot,
    output logic        [upti_pkg::SITE_W-1:0] o_grid_write_index,
    output logic signed [upti_pkg::KIND_W-1:0] o_grid_write_type
);

    localparam int AW = upti_pkg::ADDR_W;
    localparam int CW = upti_pkg::CNT_W;

    upti_pkg::t_entry mem [upti_pkg::CAPACITY];
    upti_pkg::t_entry r_rd_data;

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    upti_pkg::t_entry mem_wdata;

    logic [upti_pkg::CFG_W-1:0]  r_site_count;
    logic [upti_pkg::SITE_W-1:0] r_idx;
    logic [upti_pkg::KIND_W-1:0] r_kind;
    logic                        r_mob;
    logic [CW-1:0] r_entry_count, n_entry_count;
    logic [CW-1:0] r_mobile_count, n_mobile_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_target, n_target;
    logic [AW-1:0] r_waddr, n_waddr;
    logic          r_rd_vld, n_rd_vld;
    logic          issue;

    logic [1:0]                  r_status;
    logic [upti_pkg::SLOT_W-1:0] r_slot;
    logic [upti_pkg::SITE_W-1:0] r_gw_index;
    logic [upti_pkg::KIND_W-1:0] r_gw_type;

    assign o_stat.invalid     = ({1'b0, r_idx} >= r_site_count);
    assign o_stat.full        = (r_entry_count >= CW'(upti_pkg::CAPACITY));
    assign o_stat.dup_hit     = r_rd_vld && (r_rd_data.site == r_idx);
    assign o_stat.search_done = !r_rd_vld && (r_ptr == r_entry_count);
    assign o_stat.shift_done  = !r_rd_vld && !(r_ptr > r_target);

    always_comb begin
        n_entry_count  = r_entry_count;
        n_mobile_count = r_mobile_count;
        n_ptr          = r_ptr;
        n_target       = r_target;
        n_waddr        = r_waddr;
        n_rd_vld       = r_rd_vld;
        mem_we         = 1'b0;
        mem_waddr      = r_waddr;
        mem_wdata      = r_rd_data;
        mem_re         = 1'b0;
        mem_raddr      = r_ptr[AW-1:0];
        issue          = 1'b0;

        if (i_cmd.load) begin
            n_ptr    = '0;
            n_rd_vld = 1'b0;
        end

        // Walk up the occupied slots, one read per cycle, compare in the next cycle
        if (i_cmd.search_step) begin
            issue    = (r_ptr < r_entry_count);
            mem_re   = issue;
            n_ptr    = issue ? r_ptr + 1'b1 : r_ptr;
            n_rd_vld = issue;
        end

        // Insertion point: end of the mobile prefix for mobile entries, end of the table otherwise
        if (i_cmd.shift_init) begin
            n_ptr    = r_entry_count;
            n_rd_vld = 1'b0;
            if (r_mob && (r_mobile_count < r_entry_count)) begin
                n_target = r_mobile_count;
            end else begin
                n_target = r_entry_count;
            end
        end

        // Move entries up one slot, top down: read below, write last read above
        if (i_cmd.shift_step) begin
            mem_we    = r_rd_vld;
            issue     = (r_ptr > r_target);
            mem_re    = issue;
            mem_raddr = AW'(r_ptr - 1'b1);
            if (issue) begin
                n_waddr = r_ptr[AW-1:0];
                n_ptr   = r_ptr - 1'b1;
            end
            n_rd_vld = issue;
        end

        if (i_cmd.place) begin
            mem_we        = 1'b1;
            mem_waddr     = r_target[AW-1:0];
            mem_wdata     = '{site: r_idx, kind: r_kind, mobile: r_mob};
            n_entry_count = r_entry_count + 1'b1;
            if (r_mob) begin
                n_mobile_count = r_target + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_site_count   <= upti_pkg::SITE_COUNT_RST;
            r_entry_count  <= '0;
            r_mobile_count <= '0;
            r_rd_vld       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_site_count <= i_cfg_wdata;
            end
            r_entry_count  <= n_entry_count;
            r_mobile_count <= n_mobile_count;
            r_rd_vld       <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_target <= n_target;
        r_waddr  <= n_waddr;
        if (i_cmd.load) begin
            r_idx  <= i_site_index;
            r_kind <= i_site_type;
            r_mob  <= i_mobile;
        end
        if (i_cmd.place) begin
            r_status   <= upti_pkg::ST_OK;
            r_slot     <= upti_pkg::SLOT_W'(r_target);
            r_gw_index <= r_idx;
            r_gw_type  <= r_kind;
        end else if (i_cmd.reject) begin
            r_status   <= i_cmd.reject_code;
            r_slot     <= '0;
            r_gw_index <= '0;
            r_gw_type  <= '0;
        end
    end

    assign o_status           = r_status;
    assign o_slot             = r_slot;
    assign o_grid_write_index = r_gw_index;
    assign o_grid_write_type  = r_gw_type;

endmodule

// ===== src/unique_partitioned_table_insert_unit.sv =====
// An invalid index or a full table is rejected at the check; a duplicate is rejected when
// the search reads its slot; an insert searches the n occupied entries, moves the s entries
// above the insertion point up one slot, and places the new entry.
// One item at a time: the next request is taken only once the unit is back in idle, after
// the result is issued; the entry memory has one read and one write port.
// A waiting result stalls the next item at its decision. Reset (synchronous, active low)
// empties the table and restores site_count.
module unique_partitioned_table_insert_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    upti_in_if.sink                    i_in,
    upti_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [upti_pkg::CFG_W-1:0] i_cfg_wdata
);

    upti_pkg::t_dp_cmd  cmd;
    upti_pkg::t_dp_stat stat;

    // Sequencer: accept a transfer in idle, then check, search, shift and place
    upti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Entry storage, counters and the result register
    upti_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_site_index       (i_in.site_index),
        .i_site_type        (i_in.site_type),
        .i_mobile           (i_in.mobile),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_status           (o_out.status),
        .o_slot             (o_out.slot),
        .o_grid_write_index (o_out.grid_write_index),
        .o_grid_write_type  (o_out.grid_write_type)
    );

endmodule
